### hdl/bqwd_pkg.sv
// Shared constants and types for the bounded queue window dispatcher.
package bqwd_pkg;

    localparam int MAX_WINDOWS_DEF = 32;
    localparam int MAX_DEPTH_DEF   = 16;

    localparam int SVC_W  = 10;
    localparam int FIN_W  = 16;
    localparam int SRV_W  = 5;
    localparam int JOBS_W = 10;
    localparam int NW_REG_W = 6;
    localparam int QD_REG_W = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [NW_REG_W-1:0] NUM_WINDOWS_RST = 6'd2;
    localparam logic [QD_REG_W-1:0] QUEUE_DEPTH_RST = 5'd1;
    localparam logic [FIN_W-1:0]    CLOSE_LIMIT_RST = 16'd540;
    localparam logic [FIN_W-1:0]    FINISH_MAX      = 16'hFFFF;
    localparam logic [JOBS_W-1:0]   JOBS_MAX        = 10'd1023;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_WINDOWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_DEPTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_LIMIT = 2'd2;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SETUP  = 8'b0000_0010,
        S_DIV    = 8'b0000_0100,
        S_SRCH   = 8'b0000_1000,
        S_SLAST  = 8'b0001_0000,
        S_CALC   = 8'b0010_0000,
        S_COMMIT = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } t_state;

endpackage

### hdl/bounded_queue_window_dispatcher.sv
// Top level: job dispatcher over bounded per-server FIFOs with earliest-head search.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one job request: service time and a
//   first-of-batch flag that empties every queue before the job is placed.
//   Output channel (o_valid / i_stall) returns one request per job: server index,
//   saturated finish time and late flag (finish time above close_limit).
//   Configuration (i_cfg_valid / o_cfg_ready) writes num_windows, queue_depth and
//   close_limit by index; write only while the block is idle.
//   Throughput: one job at a time. While the batch fills the queues the server is
//   chosen by the 10-step bit-serial round-robin modulo unit. Once the queues are
//   full the server is chosen by the head search, which reads one server head a
//   cycle from the FIFO memory through one shared comparator.
//   A finished result sits in the output register; the next job is accepted
//   while it waits. If i_stall holds that register, the following job stops
//   just before its output and the input stalls.
//   Reset (synchronous, active low) empties all queues and restores the
//   register defaults; no clearing pass is needed.
module bounded_queue_window_dispatcher #(
    parameter int MAX_WINDOWS = bqwd_pkg::MAX_WINDOWS_DEF,
    parameter int MAX_DEPTH   = bqwd_pkg::MAX_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [bqwd_pkg::SVC_W-1:0]     i_service_time,
    input  logic                           i_first_of_batch,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [bqwd_pkg::SRV_W-1:0]     o_server_index,
    output logic [bqwd_pkg::FIN_W-1:0]     o_finish_time,
    output logic                           o_late,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bqwd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bqwd_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import bqwd_pkg::*;

    localparam int WIN_W  = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam int NW_W   = $clog2(MAX_WINDOWS + 1);
    localparam int PTR_W  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int OCC_W  = $clog2(MAX_DEPTH + 1);
    localparam int SUM_W  = OCC_W + 1;
    localparam int MEM_DEPTH = MAX_WINDOWS * MAX_DEPTH;
    localparam int ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int PROD_W = NW_W + OCC_W;
    localparam int CMP_W  = (PROD_W > JOBS_W) ? PROD_W : JOBS_W;
    localparam int DCNT_W = $clog2(JOBS_W);

    t_state r_state, n_state;

    logic [NW_REG_W-1:0] r_num_windows;
    logic [QD_REG_W-1:0] r_queue_depth;
    logic [FIN_W-1:0]    r_close_limit;

    logic [OCC_W-1:0] r_occ  [MAX_WINDOWS];
    logic [PTR_W-1:0] r_head [MAX_WINDOWS];
    logic [FIN_W-1:0] r_tail [MAX_WINDOWS];
    logic [FIN_W-1:0] r_mem  [MEM_DEPTH];
    logic [FIN_W-1:0] r_rd_data;

    logic [JOBS_W-1:0] r_jobs;
    logic [SVC_W-1:0]  r_service;
    logic              r_fill;
    logic [WIN_W-1:0]  r_idx;

    logic [JOBS_W-1:0] r_div_shift;
    logic [NW_W-1:0]   r_rem;
    logic [DCNT_W-1:0] r_div_cnt;

    logic             r_cmp_v;
    logic             r_cmp_nz;
    logic [WIN_W-1:0] r_cmp_idx;
    logic [FIN_W-1:0] r_best;
    logic [WIN_W-1:0] r_best_s;

    logic [FIN_W-1:0] r_fin;
    logic [PTR_W-1:0] r_slot;
    logic [OCC_W-1:0] r_occ_new;
    logic [PTR_W-1:0] r_head_new;

    logic             r_out_valid;
    logic [SRV_W-1:0] r_out_srv;
    logic [FIN_W-1:0] r_out_fin;
    logic             r_out_late;

    logic [NW_W-1:0]   n_used;
    logic [OCC_W-1:0]  d_used;
    logic [PROD_W-1:0] nd_prod;
    logic              fill_now;
    logic              in_acc;
    logic              out_free;

    logic [NW_W:0]     div_try;
    logic [NW_W-1:0]   n_rem;

    logic [FIN_W-1:0] cmp_head;
    logic             cmp_take;
    logic [FIN_W-1:0] n_best;
    logic [WIN_W-1:0] n_best_s;
    logic             last_srv;

    logic [OCC_W-1:0]  c_occ, c_o1, c_o2;
    logic [PTR_W-1:0]  c_head, c_h1, c_h2;
    logic              c_p1, c_p2, c_p3;
    logic [FIN_W:0]    c_sum;
    logic [FIN_W-1:0]  c_fin;
    logic [SUM_W-1:0]  c_slot_sum;
    logic [PTR_W-1:0]  c_slot;

    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] res;
        if (p == PTR_W'(MAX_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = p + PTR_W'(1);
        end
        return res;
    endfunction

    // clamped register values
    always_comb begin
        if (r_num_windows == '0) begin
            n_used = NW_W'(1);
        end else if (32'(r_num_windows) > 32'(MAX_WINDOWS)) begin
            n_used = NW_W'(MAX_WINDOWS);
        end else begin
            n_used = NW_W'(r_num_windows);
        end
        if (r_queue_depth == '0) begin
            d_used = OCC_W'(1);
        end else if (32'(r_queue_depth) > 32'(MAX_DEPTH)) begin
            d_used = OCC_W'(MAX_DEPTH);
        end else begin
            d_used = OCC_W'(r_queue_depth);
        end
    end

    assign nd_prod  = PROD_W'(n_used) * PROD_W'(d_used);
    assign fill_now = CMP_W'(r_jobs) < CMP_W'(nd_prod);

    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;

    // one restoring step of jobs mod n
    always_comb begin
        div_try = {r_rem, r_div_shift[JOBS_W-1]};
        if (div_try >= (NW_W+1)'(n_used)) begin
            n_rem = NW_W'(div_try - (NW_W+1)'(n_used));
        end else begin
            n_rem = NW_W'(div_try);
        end
    end

    // shared head comparator
    assign cmp_head = r_cmp_nz ? r_rd_data : '0;
    assign cmp_take = (r_cmp_idx == '0) || (cmp_head < r_best);
    assign n_best   = cmp_take ? cmp_head : r_best;
    assign n_best_s = cmp_take ? r_cmp_idx : r_best_s;
    assign last_srv = NW_W'(r_idx) == (n_used - NW_W'(1));

    // pop/push arithmetic for the chosen server
    always_comb begin
        c_occ  = r_occ[r_idx];
        c_head = r_head[r_idx];
        c_p1   = r_fill && (c_occ >= d_used);
        c_o1   = c_occ - OCC_W'(c_p1);
        c_h1   = c_p1 ? ptr_inc(c_head) : c_head;
        if (c_o1 != '0) begin
            c_sum = {1'b0, r_tail[r_idx]} + (FIN_W+1)'(r_service);
        end else begin
            c_sum = (FIN_W+1)'(r_service);
        end
        c_fin = c_sum[FIN_W] ? FINISH_MAX : c_sum[FIN_W-1:0];
        c_p2  = c_o1 >= OCC_W'(MAX_DEPTH);
        c_o2  = c_o1 - OCC_W'(c_p2);
        c_h2  = c_p2 ? ptr_inc(c_h1) : c_h1;
        c_slot_sum = SUM_W'(c_h2) + SUM_W'(c_o2);
        if (c_slot_sum >= SUM_W'(MAX_DEPTH)) begin
            c_slot = PTR_W'(c_slot_sum - SUM_W'(MAX_DEPTH));
        end else begin
            c_slot = PTR_W'(c_slot_sum);
        end
        c_p3 = !r_fill && (c_o2 != '0);
    end

    assign rd_addr = ADDR_W'(r_idx) * ADDR_W'(MAX_DEPTH) + ADDR_W'(r_head[r_idx]);
    assign wr_addr = ADDR_W'(r_idx) * ADDR_W'(MAX_DEPTH) + ADDR_W'(r_slot);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_valid) n_state = S_SETUP;
            S_SETUP:  n_state = fill_now ? S_DIV : S_SRCH;
            S_DIV:    if (r_div_cnt == '0) n_state = S_CALC;
            S_SRCH:   if (last_srv) n_state = S_SLAST;
            S_SLAST:  n_state = S_CALC;
            S_CALC:   n_state = S_COMMIT;
            S_COMMIT: n_state = S_EMIT;
            S_EMIT:   if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_num_windows <= NUM_WINDOWS_RST;
            r_queue_depth <= QUEUE_DEPTH_RST;
            r_close_limit <= CLOSE_LIMIT_RST;
            r_jobs        <= '0;
            r_out_valid   <= 1'b0;
            for (int i = 0; i < MAX_WINDOWS; i++) begin
                r_occ[i]  <= '0;
                r_head[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_NUM_WINDOWS: r_num_windows <= i_cfg_data[NW_REG_W-1:0];
                    CFG_QUEUE_DEPTH: r_queue_depth <= i_cfg_data[QD_REG_W-1:0];
                    CFG_CLOSE_LIMIT: r_close_limit <= i_cfg_data[FIN_W-1:0];
                    default: ;
                endcase
            end
            if (in_acc && i_first_of_batch) begin
                r_jobs <= '0;
                for (int i = 0; i < MAX_WINDOWS; i++) begin
                    r_occ[i]  <= '0;
                    r_head[i] <= '0;
                end
            end
            if (r_state == S_COMMIT) begin
                r_occ[r_idx]  <= r_occ_new;
                r_head[r_idx] <= r_head_new;
                if (r_jobs != JOBS_MAX) begin
                    r_jobs <= r_jobs + JOBS_W'(1);
                end
            end
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_service <= i_service_time;
        end
        case (r_state)
            S_SETUP: begin
                r_fill      <= fill_now;
                r_idx       <= '0;
                r_cmp_v     <= 1'b0;
                r_rem       <= '0;
                r_div_shift <= r_jobs;
                r_div_cnt   <= DCNT_W'(JOBS_W - 1);
            end
            S_DIV: begin
                r_rem       <= n_rem;
                r_div_shift <= r_div_shift << 1;
                r_div_cnt   <= r_div_cnt - DCNT_W'(1);
                if (r_div_cnt == '0) begin
                    r_idx <= WIN_W'(n_rem);
                end
            end
            S_SRCH: begin
                r_cmp_v   <= 1'b1;
                r_cmp_idx <= r_idx;
                r_cmp_nz  <= r_occ[r_idx] != '0;
                if (r_cmp_v) begin
                    r_best   <= n_best;
                    r_best_s <= n_best_s;
                end
                if (!last_srv) begin
                    r_idx <= r_idx + WIN_W'(1);
                end
            end
            S_SLAST: begin
                r_idx <= n_best_s;
            end
            S_CALC: begin
                r_fin      <= c_fin;
                r_slot     <= c_slot;
                r_head_new <= c_p3 ? ptr_inc(c_h2) : c_h2;
                r_occ_new  <= c_p3 ? c_o2 : c_o2 + OCC_W'(1);
            end
            S_COMMIT: begin
                r_tail[r_idx] <= r_fin;
            end
            S_EMIT: begin
                if (out_free) begin
                    r_out_srv  <= SRV_W'(r_idx);
                    r_out_fin  <= r_fin;
                    r_out_late <= r_fin > r_close_limit;
                end
            end
            default: ;
        endcase
    end

    // finish-time FIFO storage
    always_ff @(posedge i_clk) begin
        if (r_state == S_COMMIT) begin
            r_mem[wr_addr] <= r_fin;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign o_stall        = r_state != S_IDLE;
    assign o_cfg_ready    = 1'b1;
    assign o_valid        = r_out_valid;
    assign o_server_index = r_out_srv;
    assign o_finish_time  = r_out_fin;
    assign o_late         = r_out_late;

endmodule
